>>> design/uppfs_pkg.sv
// Shared types, constants and codes for the USB-C power path fault supervisor.
`default_nettype none

package uppfs_pkg;

  localparam int unsigned PORTS      = 4;
  localparam int unsigned PORT_W     = 2;
  localparam int unsigned PORT_IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DG_W       = 10;
  localparam int unsigned LIM_W      = 3;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned FLAG_W     = 6;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CNT_W-1:0]  CNT_MAX       = 3'd7;
  localparam logic [DG_W-1:0]   DG_RESET      = 10'd100;
  localparam logic [LIM_W-1:0]  LIMIT_RESET   = 3'd3;
  localparam logic [TIME_W-1:0] DEADLINE_NEVER = '1;

  // Bit positions inside the per-port flag word.
  localparam int unsigned FL_SRC  = 0;
  localparam int unsigned FL_SNK  = 1;
  localparam int unsigned FL_TSD  = 2;
  localparam int unsigned FL_OVP  = 3;
  localparam int unsigned FL_OC5V = 4;
  localparam int unsigned FL_VCOC = 5;

  typedef enum logic [1:0] {
    REQ_STATUS   = 2'd0,
    REQ_VCONN    = 2'd1,
    REQ_SINK     = 2'd2,
    REQ_SOURCE   = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_DG    = 2'd0,
    CFG_VCONN_DG  = 2'd1,
    CFG_OCP_LIMIT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DG_W-1:0]  src_dg;
    logic [DG_W-1:0]  vconn_dg;
    logic [LIM_W-1:0] ocp_limit;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              enable;
    logic [3:0]        status_bits;
    logic [PORT_W-1:0] port;
    logic [1:0]        req_type;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] vconn_dl;
    logic [TIME_W-1:0] vbus_dl;
    logic [CNT_W-1:0]  count;
    logic [FLAG_W-1:0] flags;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] ocp_count;
    logic             refused;
    logic             cc_overvoltage;
    logic             vconn_cut;
    logic             sink_retry;
    logic             overcurrent_report;
    logic             source_cut;
    logic             sink_enabled;
    logic             source_enabled;
  } result_t;

endpackage

`default_nettype wire

>>> design/uppfs_cfg_regs.sv
// Configuration registers: deglitch times and the sink overcurrent limit.
`default_nettype none

module uppfs_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [uppfs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [uppfs_pkg::DG_W-1:0]      cfg_data_i,
  output      uppfs_pkg::cfg_t                cfg_o
);
  import uppfs_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SRC_DG:    cfg_d.src_dg    = cfg_data_i;
        CFG_VCONN_DG:  cfg_d.vconn_dg  = cfg_data_i;
        CFG_OCP_LIMIT: cfg_d.ocp_limit = cfg_data_i[LIM_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_dg    <= DG_RESET;
      cfg_q.vconn_dg  <= DG_RESET;
      cfg_q.ocp_limit <= LIMIT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> design/uppfs_eval.sv
// Next-state and result logic for one item applied to one port's state.
`default_nettype none

module uppfs_eval (
  input  wire uppfs_pkg::item_t   item_i,
  input  wire uppfs_pkg::entry_t  entry_i,
  input  wire uppfs_pkg::cfg_t    cfg_i,
  output      uppfs_pkg::entry_t  entry_o,
  output      uppfs_pkg::result_t res_o
);
  import uppfs_pkg::*;

  // Deadline is now plus the deglitch time, saturated at the largest time.
  function automatic logic [TIME_W-1:0] arm(input logic [TIME_W-1:0] now,
                                            input logic [DG_W-1:0]   dg);
    logic [TIME_W:0] sum;
    sum = {1'b0, now} + (TIME_W+1)'(dg);
    return sum[TIME_W] ? DEADLINE_NEVER : sum[TIME_W-1:0];
  endfunction

  logic [TIME_W-1:0] vbus_arm, vconn_arm;
  logic              vbus_expired, vconn_expired;

  assign vbus_arm      = arm(item_i.now_ms, cfg_i.src_dg);
  assign vconn_arm     = arm(item_i.now_ms, cfg_i.vconn_dg);
  assign vbus_expired  = item_i.now_ms > entry_i.vbus_dl;
  assign vconn_expired = item_i.now_ms > entry_i.vconn_dl;

  always_comb begin
    entry_t e;
    result_t r;
    logic [3:0] b;
    e = entry_i;
    r = '0;
    b = item_i.status_bits;
    unique case (req_e'(item_i.req_type))
      REQ_STATUS: begin
        if (b[0] && !e.flags[FL_OC5V]) begin
          e.flags[FL_OC5V] = 1'b1;
          e.vbus_dl = vbus_arm;
        end else if (b[0] && vbus_expired) begin
          e.vbus_dl = DEADLINE_NEVER;
          e.flags[FL_OC5V] = 1'b0;
          e.flags[FL_SRC]  = 1'b0;
          r.source_cut = 1'b1;
          r.overcurrent_report = 1'b1;
        end else if (!b[0]) begin
          e.flags[FL_OC5V] = 1'b0;
        end
        if (b[1] && !e.flags[FL_TSD]) begin
          e.flags[FL_TSD] = 1'b1;
          e.flags[FL_SRC] = 1'b0;
          e.flags[FL_SNK] = 1'b0;
        end else if (!b[1]) begin
          e.flags[FL_TSD] = 1'b0;
        end
        if (b[2] && !e.flags[FL_OVP]) begin
          e.flags[FL_OVP] = 1'b1;
          e.flags[FL_SRC] = 1'b0;
        end else if (!b[2]) begin
          e.flags[FL_OVP] = 1'b0;
        end
        if (b[3]) begin
          if (e.count != CNT_MAX) begin
            e.count = e.count + CNT_W'(1);
          end
          if (e.count < cfg_i.ocp_limit && e.flags[FL_SNK]) begin
            e.flags[FL_SRC] = 1'b0;
            r.sink_retry = 1'b1;
          end else begin
            e.flags[FL_SNK] = 1'b0;
          end
        end
      end
      REQ_VCONN: begin
        if (b[0] && !e.flags[FL_VCOC]) begin
          e.flags[FL_VCOC] = 1'b1;
          e.vconn_dl = vconn_arm;
        end else if (b[0] && vconn_expired) begin
          e.vconn_dl = DEADLINE_NEVER;
          e.flags[FL_VCOC] = 1'b0;
          r.vconn_cut = 1'b1;
        end else if (!b[0]) begin
          e.flags[FL_VCOC] = 1'b0;
        end
        // Battery overvoltage reinitializes the port but keeps its deadlines.
        if (b[1]) begin
          e.flags = '0;
          e.count = '0;
          r.cc_overvoltage = 1'b1;
        end
      end
      REQ_SINK: begin
        if (!item_i.enable) begin
          e.count = '0;
          e.flags[FL_SNK] = 1'b0;
        end else if (e.count > cfg_i.ocp_limit) begin
          r.refused = 1'b1;
        end else begin
          e.flags[FL_SRC] = 1'b0;
          e.flags[FL_SNK] = 1'b1;
        end
      end
      REQ_SOURCE: begin
        if (item_i.enable) begin
          e.flags[FL_SRC] = 1'b1;
          e.flags[FL_SNK] = 1'b0;
        end else begin
          e.flags[FL_SRC] = 1'b0;
        end
      end
      default: e = entry_i;
    endcase
    r.source_enabled = e.flags[FL_SRC];
    r.sink_enabled   = e.flags[FL_SNK];
    r.ocp_count      = e.count;
    entry_o = e;
    res_o   = r;
  end

endmodule

`default_nettype wire

>>> design/usbc_power_path_fault_supervisor_top.sv
// Top level of the USB-C power path fault supervisor.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tuser req_type, tdata item fields
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata result fields
//  cfg       in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output is ready. The input register captures
// each transaction; the result register is loaded from it once the output has room.
// The per-port state is read, updated and written back on advance, so items for the
// same port may follow each other directly. Reset clears all port state and loads the
// default configuration. A stalled output holds its result while one more item waits in
// the input register; the input stalls only when both are full.
`default_nettype none

module usbc_power_path_fault_supervisor_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // tuser: [1:0] req_type
  input  wire logic [1:0]  s_axis_tuser,
  // tdata: [1:0] port, [5:2] status_bits, [6] enable, [38:7] now_ms, [39] zero
  input  wire logic [39:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: [0] source_enabled, [1] sink_enabled, [2] source_cut, [3] overcurrent_report,
  //        [4] sink_retry, [5] vconn_cut, [6] cc_overvoltage, [7] refused,
  //        [10:8] ocp_count, [15:11] zero
  output      logic [15:0] m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [uppfs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [uppfs_pkg::DG_W-1:0]      cfg_data_i
);
  import uppfs_pkg::*;

  localparam logic [PORT_W:0] PORT_CNT = (PORT_W+1)'(PORTS);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  result_t res_q, res_d;
  logic    out_valid_q;
  entry_t  state_q [PORTS];
  entry_t  entry_rd, entry_wr;
  result_t res_eval;
  logic    advance, port_ok;
  logic [PORT_IDX_W-1:0] idx;

  uppfs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.req_type    <= s_axis_tuser;
      item_q.port        <= s_axis_tdata[1:0];
      item_q.status_bits <= s_axis_tdata[5:2];
      item_q.enable      <= s_axis_tdata[6];
      item_q.now_ms      <= s_axis_tdata[38:7];
    end
  end

  assign idx      = item_q.port[PORT_IDX_W-1:0];
  assign port_ok  = {1'b0, item_q.port} < PORT_CNT;
  assign entry_rd = state_q[idx];

  uppfs_eval u_eval (
    .item_i  (item_q),
    .entry_i (entry_rd),
    .cfg_i   (cfg),
    .entry_o (entry_wr),
    .res_o   (res_eval)
  );

  // A port number beyond the implemented ports yields an all-zero result.
  assign res_d = port_ok ? res_eval : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PORTS; i++) begin
        state_q[i] <= '0;
      end
    end else if (advance && port_ok) begin
      state_q[idx] <= entry_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, res_q};

endmodule

`default_nettype wire

>>> tb/sv/supervisor_result_checker.sv
`timescale 1ns / 1ps
// Checker that predicts each fault supervisor result and compares it with the output stream.
module supervisor_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [1:0]                      s_axis_tuser,
  input  logic [39:0]                     s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [15:0]                     m_axis_tdata,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [uppfs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [uppfs_pkg::DG_W-1:0]      cfg_data_i,
  output int unsigned                     mismatch_count_o,
  output int unsigned                     pending_o
);
  import uppfs_pkg::*;

  logic [FLAG_W-1:0] port_state [PORTS];
  logic [CNT_W-1:0]  oc_tally   [PORTS];
  logic [TIME_W-1:0] vbus_due   [PORTS];
  logic [TIME_W-1:0] vconn_due  [PORTS];
  logic [DG_W-1:0]   src_dg;
  logic [DG_W-1:0]   vconn_dg;
  logic [LIM_W-1:0]  oc_limit;
  result_t           expected_results [$];

  initial begin
    mismatch_count_o = 0;
    pending_o = 0;
  end

  // Reports a new assertion of a fault level and tracks the level in the flag word.
  function automatic logic rise(inout logic [FLAG_W-1:0] fl, input logic level,
                                input int unsigned pos);
    logic fresh;
    fresh = level && !fl[pos];
    fl[pos] = level;
    return fresh;
  endfunction

  function automatic logic [TIME_W-1:0] arm_deadline(input logic [TIME_W-1:0] now,
                                                     input logic [DG_W-1:0] dg);
    logic [TIME_W:0] sum;
    sum = {1'b0, now} + {{(TIME_W + 1 - DG_W){1'b0}}, dg};
    return sum[TIME_W] ? DEADLINE_NEVER : sum[TIME_W-1:0];
  endfunction

  function automatic result_t supervise_item(input item_t it);
    result_t               r;
    logic [FLAG_W-1:0]     fl;
    logic [CNT_W-1:0]      cnt;
    logic [PORT_IDX_W-1:0] p;
    r = '0;
    if (32'(it.port) >= PORTS) return r;
    p   = it.port[PORT_IDX_W-1:0];
    fl  = port_state[p];
    cnt = oc_tally[p];
    case (req_e'(it.req_type))
      REQ_STATUS: begin
        if (rise(fl, it.status_bits[0], FL_OC5V)) begin
          vbus_due[p] = arm_deadline(it.now_ms, src_dg);
        end else if (it.status_bits[0] && it.now_ms > vbus_due[p]) begin
          vbus_due[p] = DEADLINE_NEVER;
          fl[FL_OC5V] = 1'b0;
          fl[FL_SRC] = 1'b0;
          r.source_cut = 1'b1;
          r.overcurrent_report = 1'b1;
        end
        if (rise(fl, it.status_bits[1], FL_TSD)) begin
          fl[FL_SRC] = 1'b0;
          fl[FL_SNK] = 1'b0;
        end
        if (rise(fl, it.status_bits[2], FL_OVP)) fl[FL_SRC] = 1'b0;
        if (it.status_bits[3]) begin
          if (cnt != CNT_MAX) cnt = cnt + 1'b1;
          if (cnt < oc_limit && fl[FL_SNK]) begin
            fl[FL_SRC] = 1'b0;
            r.sink_retry = 1'b1;
          end else begin
            fl[FL_SNK] = 1'b0;
          end
        end
      end
      REQ_VCONN: begin
        if (rise(fl, it.status_bits[0], FL_VCOC)) begin
          vconn_due[p] = arm_deadline(it.now_ms, vconn_dg);
        end else if (it.status_bits[0] && it.now_ms > vconn_due[p]) begin
          vconn_due[p] = DEADLINE_NEVER;
          fl[FL_VCOC] = 1'b0;
          r.vconn_cut = 1'b1;
        end
        // Battery overvoltage wipes the port after the VCONN handling; deadlines survive.
        if (it.status_bits[1]) begin
          fl = '0;
          cnt = '0;
          r.cc_overvoltage = 1'b1;
        end
      end
      REQ_SINK: begin
        if (!it.enable) begin
          cnt = '0;
          fl[FL_SNK] = 1'b0;
        end else if (cnt > oc_limit) begin
          r.refused = 1'b1;
        end else begin
          fl[FL_SRC] = 1'b0;
          fl[FL_SNK] = 1'b1;
        end
      end
      default: begin
        if (it.enable) begin
          fl[FL_SRC] = 1'b1;
          fl[FL_SNK] = 1'b0;
        end else begin
          fl[FL_SRC] = 1'b0;
        end
      end
    endcase
    port_state[p] = fl;
    oc_tally[p] = cnt;
    r.source_enabled = fl[FL_SRC];
    r.sink_enabled = fl[FL_SNK];
    r.ocp_count = cnt;
    return r;
  endfunction

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatch_count_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t want;
    result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < PORTS; i++) begin
        port_state[i] = '0;
        oc_tally[i] = '0;
        vbus_due[i] = '0;
        vconn_due[i] = '0;
      end
      src_dg = DG_RESET;
      vconn_dg = DG_RESET;
      oc_limit = LIMIT_RESET;
      expected_results.delete();
      pending_o = 0;
    end else begin
      // A result always belongs to an earlier input transaction, so it is checked first.
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[10:0]);
        if (expected_results.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: unexpected result, expected none, actual 0x%h", $time, m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          compare_field("source_enabled", want.source_enabled, got.source_enabled);
          compare_field("sink_enabled", want.sink_enabled, got.sink_enabled);
          compare_field("source_cut", want.source_cut, got.source_cut);
          compare_field("overcurrent_report", want.overcurrent_report, got.overcurrent_report);
          compare_field("sink_retry", want.sink_retry, got.sink_retry);
          compare_field("vconn_cut", want.vconn_cut, got.vconn_cut);
          compare_field("cc_overvoltage", want.cc_overvoltage, got.cc_overvoltage);
          compare_field("refused", want.refused, got.refused);
          compare_field("ocp_count", want.ocp_count, got.ocp_count);
          compare_field("tdata padding", 0, m_axis_tdata[15:11]);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SRC_DG:    src_dg = cfg_data_i;
          CFG_VCONN_DG:  vconn_dg = cfg_data_i;
          CFG_OCP_LIMIT: oc_limit = cfg_data_i[LIM_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(supervise_item(item_t'({s_axis_tdata[38:0], s_axis_tuser})));
      pending_o = expected_results.size();
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the fault supervisor testbench: clock, reset, stimulus, output back-pressure and verdict.
module tb_top;
  import uppfs_pkg::*;

  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 242;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [1:0]           s_axis_tuser;
  logic [39:0]          s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [15:0]          m_axis_tdata;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DG_W-1:0]      cfg_data_i;

  int unsigned mismatch_count;
  int unsigned pending;

  bit calm      = 1'b0;
  bit hold_go   = 1'b0;
  bit hold_done = 1'b0;

  logic [TIME_W-1:0] clock_ms;
  logic              oc5_level   [PORTS];
  logic              vconn_level [PORTS];

  // Phase settings; the last phase is drawn at random.
  logic [DG_W-1:0]  src_plan   [PHASES] = '{10'd100, 10'd1, 10'd1000, 10'd0, 10'd1023, 10'd0};
  logic [DG_W-1:0]  vconn_plan [PHASES] = '{10'd100, 10'd1000, 10'd1, 10'd0, 10'd1023, 10'd0};
  logic [LIM_W-1:0] limit_plan [PHASES] = '{3'd3, 3'd1, 3'd6, 3'd0, 3'd7, 3'd0};

  usbc_power_path_fault_supervisor_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  supervisor_result_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tuser     (s_axis_tuser),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Output side: random back-pressure, plus one long hold-off once the stimulus asks for it.
  initial begin : result_sink
    int unsigned held;
    held = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        m_axis_tready <= 1'b0;
        held++;
        if (held == HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 11);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input req_e kind, input logic [PORT_W-1:0] port,
                           input logic [3:0] bits, input logic en,
                           input logic [TIME_W-1:0] stamp);
    while (!calm && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, stamp, en, bits, port};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [DG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Mostly plausible fault traffic with per-port fault levels that persist across samples.
  task automatic random_item();
    logic [PORT_W-1:0] port;
    logic [3:0]        bits;
    logic              en;
    logic [TIME_W-1:0] stamp;
    req_e              kind;
    int unsigned       pick;
    port = PORT_W'($urandom_range(PORTS - 1));
    clock_ms = clock_ms + TIME_W'($urandom_range(40));
    stamp = clock_ms;
    bits = 4'($urandom);
    en = 1'($urandom);
    if ($urandom_range(99) < 8) begin
      kind = req_e'(2'($urandom_range(3)));
      stamp = $urandom;
    end else begin
      if ($urandom_range(99) < 12) oc5_level[port] = ~oc5_level[port];
      if ($urandom_range(99) < 12) vconn_level[port] = ~vconn_level[port];
      pick = $urandom_range(99);
      if (pick < 50) begin
        kind = REQ_STATUS;
        bits = {$urandom_range(99) < 15, $urandom_range(99) < 10, $urandom_range(99) < 10,
                oc5_level[port]};
      end else if (pick < 65) begin
        kind = REQ_VCONN;
        bits = {2'($urandom), $urandom_range(99) < 4, vconn_level[port]};
      end else if (pick < 85) begin
        kind = REQ_SINK;
        en = ($urandom_range(99) >= 15);
      end else begin
        kind = REQ_SOURCE;
        en = ($urandom_range(99) >= 30);
      end
    end
    send_item(kind, port, bits, en, stamp);
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = '0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_SRC_DG;
    cfg_data_i    = '0;
    clock_ms      = '0;
    for (int i = 0; i < PORTS; i++) begin
      oc5_level[i] = 1'b0;
      vconn_level[i] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part with the reset configuration: deglitch 100 ms, limit 3.
    send_item(REQ_SOURCE, 2'd0, 4'b0000, 1'b1, 32'd0);
    send_item(REQ_STATUS, 2'd0, 4'b0001, 1'b0, 32'd1000);
    send_item(REQ_STATUS, 2'd0, 4'b0001, 1'b0, 32'd1100);   // at the deadline: no cut
    send_item(REQ_STATUS, 2'd0, 4'b0001, 1'b0, 32'd1101);   // past it: cut and report
    send_item(REQ_STATUS, 2'd0, 4'b0001, 1'b0, 32'd1102);   // still present: re-armed
    send_item(REQ_SINK,   2'd1, 4'b0000, 1'b1, 32'd5);
    for (int i = 0; i < 4; i++)
      send_item(REQ_STATUS, 2'd1, 4'b1000, 1'b0, 32'(10 + i));
    send_item(REQ_SINK,   2'd1, 4'b0000, 1'b1, 32'd20);     // count above limit: refused
    send_item(REQ_SINK,   2'd1, 4'b1111, 1'b0, 32'd21);     // disable clears the count
    send_item(REQ_SOURCE, 2'd2, 4'b0000, 1'b1, 32'd30);
    send_item(REQ_STATUS, 2'd2, 4'b0010, 1'b1, 32'd31);
    send_item(REQ_SOURCE, 2'd3, 4'b0000, 1'b1, 32'd32);
    send_item(REQ_STATUS, 2'd3, 4'b0100, 1'b0, 32'd33);
    send_item(REQ_VCONN,  2'd3, 4'b0001, 1'b0, 32'd0);
    send_item(REQ_VCONN,  2'd3, 4'b0001, 1'b0, 32'hFFFF_FFF0);
    // Arming near the top of the time range saturates the deadline.
    send_item(REQ_VCONN,  2'd2, 4'b1101, 1'b1, 32'hFFFF_FFC0);
    send_item(REQ_VCONN,  2'd2, 4'b0001, 1'b0, 32'hFFFF_FFFF);
    send_item(REQ_VCONN,  2'd0, 4'b1110, 1'b1, 32'd40);
    send_item(REQ_STATUS, 2'd1, 4'b1111, 1'b1, 32'hFFFF_FFFF);
    send_item(REQ_SOURCE, 2'd1, 4'b0000, 1'b0, 32'd50);
    send_item(REQ_STATUS, 2'd3, 4'b0000, 1'b0, 32'd0);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES - 1) begin
        src_plan[phase] = DG_W'($urandom_range(1, 1000));
        vconn_plan[phase] = DG_W'($urandom_range(1, 1000));
        limit_plan[phase] = LIM_W'($urandom_range(1, 6));
      end
      cfg_write(CFG_SRC_DG, src_plan[phase]);
      cfg_write(CFG_VCONN_DG, vconn_plan[phase]);
      cfg_write(CFG_OCP_LIMIT, {{(DG_W - LIM_W){1'b0}}, limit_plan[phase]});
      // The longest deglitch phase starts just below the top of the time range.
      clock_ms = (phase == 4) ? 32'hFFFF_FE00 : ((phase == 0) ? '0 : $urandom);
      calm = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == 100) hold_go = 1'b1;
        random_item();
      end
      calm = 1'b0;
      drain();
    end

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/uppfs_pkg.sv
design/uppfs_cfg_regs.sv
design/uppfs_eval.sv
design/usbc_power_path_fault_supervisor_top.sv
tb/sv/supervisor_result_checker.sv
tb/sv/tb_top.sv
